@@ rtl/plie_pkg.sv @@
// shared types, constants and helpers of the plc instruction-list executor
// used by every rtl module of the block; depends on nothing
`default_nettype none
package plie_pkg;

	localparam int NUM_ELEMENTS = 64;
	localparam int STACK_DEPTH  = 16;
	localparam int AW = $clog2(NUM_ELEMENTS);
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] MODE_SCAN  = 3'd0;
	localparam logic [2:0] MODE_INSTR = 3'd1;
	localparam logic [2:0] MODE_TICK  = 3'd2;
	localparam logic [2:0] MODE_WRITE = 3'd3;
	localparam logic [2:0] MODE_READ  = 3'd4;
	localparam logic [2:0] MODE_KIND  = 3'd5;

	localparam logic [3:0] OP_LD  = 4'd0;
	localparam logic [3:0] OP_LDI = 4'd1;
	localparam logic [3:0] OP_AND = 4'd2;
	localparam logic [3:0] OP_ANI = 4'd3;
	localparam logic [3:0] OP_ANB = 4'd4;
	localparam logic [3:0] OP_OR  = 4'd5;
	localparam logic [3:0] OP_ORI = 4'd6;
	localparam logic [3:0] OP_ORB = 4'd7;
	localparam logic [3:0] OP_OUT = 4'd8;
	localparam logic [3:0] OP_SET = 4'd9;
	localparam logic [3:0] OP_RST = 4'd10;

	localparam logic [1:0] KIND_VAR     = 2'd0;
	localparam logic [1:0] KIND_TIMER   = 2'd1;
	localparam logic [1:0] KIND_COUNTER = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FEW   = 2'd2;
	localparam logic [1:0] STAT_FULL  = 2'd3;

	typedef enum logic [2:0] {
		CLS_SCAN, CLS_INSTR, CLS_TICK, CLS_WRITE, CLS_READ, CLS_KIND, CLS_NONE
	} cls_t;

	typedef struct packed {
		cls_t               cls;
		logic [3:0]         opcode;
		logic [5:0]         idx;
		logic               idx_ok;
		logic               kind_ok;
		logic signed [15:0] preset;
		logic signed [15:0] wval;
		logic [1:0]         kind;
		logic [14:0]        tick;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [15:0] read_value;
		logic [4:0]         depth;
		logic signed [15:0] top;
	} res_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] value;
		logic signed [15:0] elapsed;
		logic signed [15:0] preset;
	} elem_t;

	function automatic logic signed [15:0] elem_out(elem_t e);
		logic signed [15:0] r;
		case (e.kind)
			KIND_TIMER:   r = (e.elapsed >= e.preset) ? e.value : 16'sd0;
			KIND_COUNTER: r = (e.elapsed >= e.preset) ? 16'sd1 : 16'sd0;
			default:      r = e.value;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/plie_front.sv @@
// front end: accepts items, classifies them and queues them for the back end
// depends on plie_pkg
`default_nettype none
module plie_front (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	output logic               full,
	input  wire  [2:0]         mode,
	input  wire  [3:0]         opcode,
	input  wire  [5:0]         element_index,
	input  wire  signed [15:0] preset_value,
	input  wire  signed [15:0] write_value,
	input  wire  [1:0]         element_kind,
	input  wire  [14:0]        tick_ms,
	input  wire                clearing,
	output logic               cmd_valid,
	output plie_pkg::cmd_t     cmd,
	input  wire                cmd_pop
);
	import plie_pkg::*;

	cmd_t       buf_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	cmd_t       c;
	logic       acc;

	always_comb begin
		c.opcode  = opcode;
		c.idx     = element_index;
		c.idx_ok  = int'(element_index) < NUM_ELEMENTS;
		c.kind_ok = element_kind <= KIND_COUNTER;
		c.preset  = preset_value;
		c.wval    = write_value;
		c.kind    = element_kind;
		c.tick    = tick_ms;
		case (mode)
			MODE_SCAN:  c.cls = CLS_SCAN;
			MODE_INSTR: c.cls = CLS_INSTR;
			MODE_TICK:  c.cls = CLS_TICK;
			MODE_WRITE: c.cls = CLS_WRITE;
			MODE_READ:  c.cls = CLS_READ;
			MODE_KIND:  c.cls = CLS_KIND;
			default:    c.cls = CLS_NONE;
		endcase
	end

	assign full      = (cnt_q == 2'd2) || clearing;
	assign acc       = push && !full;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (acc) begin
			buf_q[wr_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) wr_q <= !wr_q;
			if (cmd_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(cmd_pop);
		end
	end

endmodule
`default_nettype wire

@@ rtl/plie_back.sv @@
// back end: element memory, accumulator stack and the execution sequencer
// depends on plie_pkg
`default_nettype none
module plie_back (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	input  plie_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	input  wire                res_room,
	output logic               res_push,
	output plie_pkg::res_t     res,
	output logic               clearing
);
	import plie_pkg::*;

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SWEEP, ST_EXEC} state_t;

	localparam logic [AW-1:0] LAST = AW'(NUM_ELEMENTS - 1);

	state_t             state_q, n_state;
	logic [AW-1:0]      ptr_q, n_ptr;
	cmd_t               cmd_q;
	elem_t              mem_q [NUM_ELEMENTS];
	elem_t              rdata_q;
	logic signed [15:0] below_q [STACK_DEPTH];
	logic signed [15:0] below_rd_q;
	logic signed [15:0] top_q, n_top;
	logic [CW-1:0]      cnt_q, n_cnt, cp;
	logic               pop_q, n_pop;

	logic               rd_en, wr_en, bw_en, fire;
	logic [AW-1:0]      rd_addr, wr_addr;
	elem_t              wr_data;
	logic [SW-1:0]      bw_addr;
	logic signed [15:0] eo, inv, opnd;
	logic signed [16:0] cc;
	logic signed [17:0] tsum, tpre;
	logic [1:0]         st;

	assign clearing = state_q == ST_CLEAR;

	always_comb begin
		n_state = state_q;
		n_ptr   = ptr_q;
		cmd_pop = 1'b0;
		rd_en   = 1'b0;
		rd_addr = AW'(cmd.idx);
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = rdata_q;
		bw_en   = 1'b0;
		bw_addr = SW'(cnt_q - CW'(1));
		n_top   = top_q;
		n_cnt   = cnt_q;
		n_pop   = pop_q;
		st      = STAT_OK;
		res_push = 1'b0;
		fire    = 1'b0;
		cp      = cnt_q;
		cc      = '0;
		tsum    = $signed({{2{rdata_q.elapsed[15]}}, rdata_q.elapsed})
		        + $signed({3'b000, cmd_q.tick});
		tpre    = $signed({{2{rdata_q.preset[15]}}, rdata_q.preset});
		eo      = cmd_q.idx_ok ? elem_out(rdata_q) : 16'sd0;
		inv     = (eo == 16'sd0) ? 16'sd1 : 16'sd0;
		opnd    = (cmd_q.opcode == OP_ANI || cmd_q.opcode == OP_ORI) ? inv : eo;
		res.read_value = 16'sd0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_data = '0;
				n_ptr   = ptr_q + AW'(1);
				if (ptr_q == LAST) begin
					n_ptr   = '0;
					n_state = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					rd_en   = 1'b1;
					n_ptr   = '0;
					if (cmd.cls == CLS_TICK) begin
						rd_addr = '0;
						n_state = ST_SWEEP;
					end else begin
						n_state = ST_EXEC;
					end
				end
			end
			ST_SWEEP: begin
				// running timers move toward their preset, idle ones restart
				if (rdata_q.kind == KIND_TIMER) begin
					wr_en = 1'b1;
					if (rdata_q.value > 16'sd0)
						wr_data.elapsed = (tsum < tpre) ? tsum[15:0] : rdata_q.preset;
					else
						wr_data.elapsed = 16'sd0;
				end
				rd_en   = 1'b1;
				rd_addr = ptr_q + AW'(1);
				n_ptr   = ptr_q + AW'(1);
				if (ptr_q == LAST) n_state = ST_EXEC;
			end
			ST_EXEC: begin
				if (res_room) begin
					fire     = 1'b1;
					res_push = 1'b1;
					n_state  = ST_IDLE;
					wr_addr  = AW'(cmd_q.idx);
					case (cmd_q.cls)
						CLS_SCAN: begin
							n_cnt = '0;
							n_pop = 1'b0;
						end
						CLS_WRITE: begin
							wr_en = cmd_q.idx_ok;
							wr_data.value = cmd_q.wval;
						end
						CLS_KIND: begin
							wr_en = cmd_q.idx_ok && cmd_q.kind_ok;
							wr_data.kind = cmd_q.kind;
						end
						CLS_READ: res.read_value = eo;
						CLS_INSTR: begin
							case (cmd_q.opcode)
								OP_LD, OP_LDI: begin
									if (!pop_q && cnt_q >= CW'(STACK_DEPTH)) begin
										st = STAT_FULL;
									end else begin
										if (pop_q) begin
											cp = (cnt_q != '0) ? cnt_q - CW'(1) : '0;
										end else if (cnt_q != '0) begin
											bw_en = 1'b1;
										end
										n_top = (cmd_q.opcode == OP_LD) ? eo : inv;
										n_cnt = cp + CW'(1);
										n_pop = 1'b0;
									end
								end
								OP_AND, OP_ANI, OP_OR, OP_ORI: begin
									if (cnt_q == '0) st = STAT_EMPTY;
									else if (cmd_q.opcode == OP_AND || cmd_q.opcode == OP_ANI)
										n_top = top_q & opnd;
									else
										n_top = top_q | opnd;
								end
								OP_ANB, OP_ORB: begin
									if (cnt_q < CW'(2)) begin
										st = STAT_FEW;
									end else begin
										n_top = (cmd_q.opcode == OP_ANB) ? (top_q & below_rd_q)
										                                 : (top_q | below_rd_q);
										n_cnt = cnt_q - CW'(1);
									end
								end
								OP_OUT: begin
									if (cnt_q == '0) begin
										st = STAT_EMPTY;
									end else begin
										n_pop = 1'b1;
										wr_en = cmd_q.idx_ok;
										wr_data.value = top_q;
										if (rdata_q.kind == KIND_TIMER ||
										    rdata_q.kind == KIND_COUNTER)
											wr_data.preset = cmd_q.preset;
										// counters count rising inputs, saturating at the limit
										if (rdata_q.kind == KIND_COUNTER &&
										    rdata_q.value == 16'sd0 && top_q != 16'sd0) begin
											cc = $signed({rdata_q.elapsed[15], rdata_q.elapsed})
											   + 17'sd1;
											wr_data.elapsed =
												(cc < $signed({cmd_q.preset[15], cmd_q.preset}))
												? cc[15:0] : cmd_q.preset;
										end
									end
								end
								OP_SET, OP_RST: begin
									if (cnt_q == '0) begin
										st = STAT_EMPTY;
									end else if (top_q != 16'sd0) begin
										n_pop = 1'b1;
										wr_en = cmd_q.idx_ok;
										if (cmd_q.opcode == OP_SET) begin
											wr_data.value = top_q;
											if (rdata_q.kind == KIND_COUNTER)
												wr_data.preset = rdata_q.elapsed;
										end else begin
											wr_data.value = 16'sd0;
											if (rdata_q.kind == KIND_COUNTER)
												wr_data.elapsed = 16'sd0;
										end
									end
								end
								default: ;
							endcase
						end
						default: ;
					endcase
				end
			end
			default: n_state = ST_IDLE;
		endcase
		res.status = st;
		res.depth  = 5'(n_cnt);
		res.top    = (n_cnt != '0) ? n_top : 16'sd0;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (bw_en) below_q[bw_addr] <= top_q;
		if (state_q == ST_IDLE) below_rd_q <= below_q[SW'(cnt_q - CW'(2))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ptr_q   <= '0;
			cnt_q   <= '0;
			pop_q   <= 1'b0;
			top_q   <= '0;
			cmd_q   <= '0;
		end else begin
			state_q <= n_state;
			ptr_q   <= n_ptr;
			if (fire) begin
				cnt_q <= n_cnt;
				pop_q <= n_pop;
				top_q <= n_top;
			end
			if (cmd_pop) cmd_q <= cmd;
		end
	end

endmodule
`default_nettype wire

@@ rtl/plie_outq.sv @@
// two-entry result queue between the back end and the result ports
// depends on plie_pkg
`default_nettype none
module plie_outq (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                res_push,
	input  plie_pkg::res_t     res,
	output logic               res_room,
	output logic               empty,
	input  wire                pop,
	output plie_pkg::res_t     head
);
	import plie_pkg::*;

	res_t       buf_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       take;

	assign res_room = cnt_q != 2'd2;
	assign empty    = cnt_q == 2'd0;
	assign take     = pop && !empty;
	assign head     = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (res_push) buf_q[wr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (res_push) wr_q <= !wr_q;
			if (take) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(res_push) - 2'(take);
		end
	end

endmodule
`default_nettype wire

@@ rtl/plc_ladder_instruction_executor_top.sv @@
// top level of the plc instruction-list executor: front end, back end, result queue
// depends on plie_pkg, plie_front, plie_back and plie_outq
//
//  channel  | handshake   | fields
//  ---------+-------------+--------------------------------------------------------
//  input    | push / full | mode opcode element_index preset_value write_value
//           |             | element_kind tick_ms
//  result   | empty / pop | status read_value stack_depth stack_top
//
// an item goes through two steps in the back end: an element-memory and stack read,
// then an execute-and-write step; a timer tick first walks the whole element memory,
// one element per cycle, before its execute step
// after reset a clearing pass over every element zeroes the element memory;
// full stays high during it
// a two-entry queue on each side lets the front accept while the back works,
// and the back stalls in its execute cycle only when the result queue is full
`default_nettype none
module plc_ladder_instruction_executor_top (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	output logic               full,
	input  wire  [2:0]         mode,
	input  wire  [3:0]         opcode,
	input  wire  [5:0]         element_index,
	input  wire  signed [15:0] preset_value,
	input  wire  signed [15:0] write_value,
	input  wire  [1:0]         element_kind,
	input  wire  [14:0]        tick_ms,
	output logic               empty,
	input  wire                pop,
	output logic [1:0]         status,
	output logic signed [15:0] read_value,
	output logic [4:0]         stack_depth,
	output logic signed [15:0] stack_top
);
	import plie_pkg::*;

	// front to back command queue
	logic  cmd_valid, cmd_pop, clearing;
	cmd_t  cmd;
	// back to result queue
	logic  res_push, res_room;
	res_t  res, head;

	plie_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.mode          (mode),
		.opcode        (opcode),
		.element_index (element_index),
		.preset_value  (preset_value),
		.write_value   (write_value),
		.element_kind  (element_kind),
		.tick_ms       (tick_ms),
		.clearing      (clearing),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop)
	);

	plie_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_room  (res_room),
		.res_push  (res_push),
		.res       (res),
		.clearing  (clearing)
	);

	plie_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_room (res_room),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	// oldest result drives the ports
	assign status      = head.status;
	assign read_value  = head.read_value;
	assign stack_depth = head.depth;
	assign stack_top   = head.top;

endmodule
`default_nettype wire

@@ test/plc_ladder_instruction_executor_top_test.sv @@
// testbench of the plc instruction-list executor top level: directed and random items
// predicts every result with an internal model of stack and element store; depends on plie_pkg
`timescale 1ns / 100ps
`default_nettype none
module plc_ladder_instruction_executor_top_test;
	import plie_pkg::*;

	// one accepted input item
	typedef struct {
		logic [2:0]         mode;
		logic [3:0]         opcode;
		logic [5:0]         idx;
		logic signed [15:0] preset;
		logic signed [15:0] wval;
		logic [1:0]         kind;
		logic [14:0]        tick;
	} plc_item_t;

	// one result of the block
	typedef struct {
		logic [1:0]         status;
		logic signed [15:0] rd;
		logic [4:0]         depth;
		logic signed [15:0] top;
	} plc_result_t;

	// ladder machine model plus the queue of results it has predicted
	class ladder_scoreboard;
		logic [1:0]         kinds[NUM_ELEMENTS];
		logic signed [15:0] values[NUM_ELEMENTS];
		logic signed [15:0] elapsed[NUM_ELEMENTS];
		logic signed [15:0] limits[NUM_ELEMENTS];
		logic [15:0]        acc[STACK_DEPTH];
		int                 acc_n;
		bit                 pop_flag;
		plc_result_t        pending[$];
		int                 errors;

		function new();
			for (int i = 0; i < NUM_ELEMENTS; i++) begin
				kinds[i] = KIND_VAR;
				values[i] = '0;
				elapsed[i] = '0;
				limits[i] = '0;
			end
			for (int i = 0; i < STACK_DEPTH; i++)
				acc[i] = '0;
			acc_n = 0;
			pop_flag = 0;
			errors = 0;
		endfunction

		function logic signed [15:0] output_of(int i);
			logic signed [15:0] r;
			case (kinds[i])
				KIND_TIMER:   r = (elapsed[i] >= limits[i]) ? values[i] : 16'sd0;
				KIND_COUNTER: r = (elapsed[i] >= limits[i]) ? 16'sd1 : 16'sd0;
				default:      r = values[i];
			endcase
			return r;
		endfunction

		function logic [1:0] run_instruction(logic [3:0] op, int i, logic signed [15:0] p);
			logic [15:0]        operand;
			logic [15:0]        inverse;
			logic [15:0]        t;
			logic signed [15:0] old;
			operand = output_of(i);
			inverse = (output_of(i) == 0) ? 16'd1 : 16'd0;
			case (op)
				OP_LD, OP_LDI: begin
					if (!pop_flag && acc_n >= STACK_DEPTH)
						return STAT_FULL;
					if (pop_flag) begin
						if (acc_n > 0)
							acc_n--;
						pop_flag = 0;
					end
					acc[acc_n] = (op == OP_LD) ? operand : inverse;
					acc_n++;
				end
				OP_AND, OP_ANI, OP_OR, OP_ORI: begin
					if (acc_n == 0)
						return STAT_EMPTY;
					if (op == OP_ANI || op == OP_ORI)
						operand = inverse;
					if (op == OP_AND || op == OP_ANI)
						acc[acc_n - 1] &= operand;
					else
						acc[acc_n - 1] |= operand;
				end
				OP_ANB, OP_ORB: begin
					if (acc_n < 2)
						return STAT_FEW;
					t = acc[acc_n - 1];
					acc_n--;
					if (op == OP_ANB)
						acc[acc_n - 1] &= t;
					else
						acc[acc_n - 1] |= t;
				end
				OP_OUT: begin
					if (acc_n == 0)
						return STAT_EMPTY;
					old = values[i];
					values[i] = acc[acc_n - 1];
					if (kinds[i] == KIND_TIMER)
						limits[i] = p;
					else if (kinds[i] == KIND_COUNTER) begin
						limits[i] = p;
						// count only on a rising input, saturating at the limit
						if (old == 0 && values[i] != 0)
							elapsed[i] = (int'(elapsed[i]) + 1 < int'(p)) ? elapsed[i] + 16'sd1 : p;
					end
					pop_flag = 1;
				end
				OP_SET, OP_RST: begin
					if (acc_n == 0)
						return STAT_EMPTY;
					// zero top: no effect at all, pop flag untouched
					if (acc[acc_n - 1] == 0)
						return STAT_OK;
					if (op == OP_SET) begin
						values[i] = acc[acc_n - 1];
						if (kinds[i] == KIND_COUNTER)
							limits[i] = elapsed[i];
					end else begin
						values[i] = '0;
						if (kinds[i] == KIND_COUNTER)
							elapsed[i] = '0;
					end
					pop_flag = 1;
				end
				default: ;
			endcase
			return STAT_OK;
		endfunction

		function void note_item(plc_item_t it);
			plc_result_t r;
			int          e;
			r.status = STAT_OK;
			r.rd = '0;
			case (it.mode)
				MODE_SCAN: begin
					acc_n = 0;
					pop_flag = 0;
				end
				MODE_INSTR: r.status = run_instruction(it.opcode, it.idx, it.preset);
				MODE_TICK:
					for (int i = 0; i < NUM_ELEMENTS; i++)
						if (kinds[i] == KIND_TIMER) begin
							if (values[i] > 0) begin
								e = int'(elapsed[i]) + int'(it.tick);
								elapsed[i] = (e < int'(limits[i])) ? e[15:0] : limits[i];
							end else
								elapsed[i] = '0;
						end
				MODE_WRITE: values[it.idx] = it.wval;
				MODE_READ: r.rd = output_of(it.idx);
				MODE_KIND:
					if (it.kind <= KIND_COUNTER)
						kinds[it.idx] = it.kind;
				default: ;
			endcase
			r.depth = 5'(acc_n);
			r.top = (acc_n > 0) ? acc[acc_n - 1] : 16'd0;
			pending = {pending, r};
		endfunction

		function void check_result(plc_result_t got);
			plc_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d", $time,
					got.status);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.rd !== want.rd) begin
				$display("%0t: read_value expected %0d actual %0d", $time, want.rd, got.rd);
				errors++;
			end
			if (got.depth !== want.depth) begin
				$display("%0t: stack_depth expected %0d actual %0d", $time, want.depth,
					got.depth);
				errors++;
			end
			if (got.top !== want.top) begin
				$display("%0t: stack_top expected %0d actual %0d", $time, want.top, got.top);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               push = 0;
	logic               full;
	logic [2:0]         mode = 0;
	logic [3:0]         opcode = 0;
	logic [5:0]         element_index = 0;
	logic signed [15:0] preset_value = 0;
	logic signed [15:0] write_value = 0;
	logic [1:0]         element_kind = 0;
	logic [14:0]        tick_ms = 0;
	logic               empty;
	logic               pop = 0;
	logic [1:0]         status;
	logic signed [15:0] read_value;
	logic [4:0]         stack_depth;
	logic signed [15:0] stack_top;

	plc_ladder_instruction_executor_top DUT (.*);

	always #10 clk = ~clk;

	ladder_scoreboard board = new();
	int               send_idle = 38;   // percent of cycles the sender idles
	int               recv_idle = 52;   // percent of cycles the receiver idles
	bit               hold_off = 0;     // long receiver stall requested
	int               quiet = 0;        // cycles with no handshake, for the watchdog

	// receiver: pops at random, samples on the rising edge
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			board.check_result('{status, read_value, stack_depth, stack_top});
	end

	// watchdog over cycles with nothing accepted
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : receiver
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				// long stall so the block backs up and raises full
				pop <= 0;
				for (n = 0; n < 300; n++)
					@(negedge clk);
				hold_off = 0;
			end
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	// offer one item and wait until it is taken; called and left at a falling edge
	task automatic send_item(plc_item_t it);
		bit taken;
		while ($urandom_range(99) < send_idle) begin
			push <= 0;
			@(negedge clk);
		end
		push <= 1;
		mode <= it.mode;
		opcode <= it.opcode;
		element_index <= it.idx;
		preset_value <= it.preset;
		write_value <= it.wval;
		element_kind <= it.kind;
		tick_ms <= it.tick;
		// full only changes at rising edges, so it is read in the low phase
		forever begin
			taken = !full;
			@(posedge clk);
			if (taken)
				break;
			@(negedge clk);
		end
		board.note_item(it);
		@(negedge clk);
	endtask

	function automatic plc_item_t make_item(int m, int op, int i, int p, int w, int k, int t);
		plc_item_t it;
		it.mode = 3'(m);
		it.opcode = 4'(op);
		it.idx = 6'(i);
		it.preset = 16'(p);
		it.wval = 16'(w);
		it.kind = 2'(k);
		it.tick = 15'(t);
		return it;
	endfunction

	// random item: mostly instructions on a small set of elements so state builds up
	function automatic plc_item_t random_item();
		plc_item_t it;
		int        r;
		it.opcode = 4'($urandom_range(15));
		it.idx = 6'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7));
		it.preset = 16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(40));
		it.wval = 16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(3));
		it.kind = 2'($urandom_range(3));
		it.tick = 15'(($urandom_range(7) == 0) ? $urandom : $urandom_range(20));
		r = $urandom_range(99);
		if (r < 6)
			it.mode = MODE_SCAN;
		else if (r < 60)
			it.mode = MODE_INSTR;
		else if (r < 66)
			it.mode = MODE_TICK;
		else if (r < 78)
			it.mode = MODE_WRITE;
		else if (r < 88)
			it.mode = MODE_READ;
		else if (r < 96)
			it.mode = MODE_KIND;
		else
			it.mode = 3'(6 + $urandom_range(1));
		if (it.mode == MODE_INSTR && $urandom_range(99) < 80)
			it.opcode = 4'($urandom_range(10));
		return it;
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: kinds, extremes, errors on an empty or short stack, full stack
		send_item(make_item(MODE_INSTR, OP_AND, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_INSTR, OP_ANB, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_INSTR, OP_OUT, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_INSTR, OP_SET, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_WRITE, 0, 63, 0, -32768, 0, 0));
		send_item(make_item(MODE_WRITE, 0, 1, 0, 32767, 0, 0));
		send_item(make_item(MODE_KIND, 0, 2, 0, 0, KIND_TIMER, 0));
		send_item(make_item(MODE_KIND, 0, 3, 0, 0, KIND_COUNTER, 0));
		send_item(make_item(MODE_KIND, 0, 4, 0, 0, 3, 0));
		for (int i = 0; i < 17; i++)
			send_item(make_item(MODE_INSTR, (i % 2) ? OP_LDI : OP_LD, i % 2 ? 5 : 63, 0,
				0, 0, 0));
		send_item(make_item(MODE_INSTR, OP_ORB, 1, 0, 0, 0, 0));
		send_item(make_item(MODE_INSTR, OP_OUT, 2, 32767, 0, 0, 0));
		send_item(make_item(MODE_INSTR, OP_OUT, 3, -32768, 0, 0, 0));
		send_item(make_item(MODE_INSTR, OP_ORI, 2, 0, 0, 0, 0));
		send_item(make_item(MODE_TICK, 0, 0, 0, 0, 0, 32767));
		send_item(make_item(MODE_READ, 0, 2, 0, 0, 0, 0));
		send_item(make_item(MODE_INSTR, OP_RST, 3, 0, 0, 0, 0));
		send_item(make_item(MODE_INSTR, 4'd15, 0, 0, 0, 0, 0));
		send_item(make_item(3'd7, 0, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_SCAN, 0, 0, 0, 0, 0, 0));

		// random phases: receiver idle heavy, sender idle heavy, no idling
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 38 : (ph == 1) ? 52 : 0;
			recv_idle = (ph == 0) ? 52 : (ph == 1) ? 38 : 0;
			for (int n = 0; n < 260; n++) begin
				if (ph == 0 && n == 100)
					hold_off = 1;
				send_item(random_item());
			end
		end
		push <= 0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/plie_pkg.sv
rtl/plie_front.sv
rtl/plie_back.sv
rtl/plie_outq.sv
rtl/plc_ladder_instruction_executor_top.sv
test/plc_ladder_instruction_executor_top_test.sv
